@@ src/ipte_pkg.sv @@
// Shared types, constants and codes of the infrared pulse timing encoder.
package ipte_pkg;

    localparam int DATA_BYTES   = 64;
    localparam int START_PULSES = 16;
    localparam int DB_AW        = $clog2(DATA_BYTES);
    localparam int SP_AW        = $clog2(START_PULSES);

    localparam int KIND_W   = 3;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 16;
    localparam int PERIOD_W = 16;
    localparam int BITPOS_W = 10;
    localparam int PULSE_W  = 5;
    localparam int MODE_W   = 3;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;

    localparam logic [BITPOS_W-1:0] BIT_POS_MAX = {BITPOS_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_EVENT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WDATA  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WPULSE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_START  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STOP   = 3'd4;

    localparam logic [MODE_W-1:0] MODE_ALT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PULSE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPACE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PAIR  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RAW   = 3'd4;

    localparam logic [CFG_AW-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_BIT_COUNT   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_PULSE_COUNT = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_HIGH_TIME   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_LOW_TIME    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_GAP_TIME    = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_REPEAT_TIME = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_REPEAT_EN   = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0]   encoding_mode;
        logic [BITPOS_W-1:0] bit_count;
        logic [PULSE_W-1:0]  start_pulse_count;
        logic [PERIOD_W-1:0] high_time;
        logic [PERIOD_W-1:0] low_time;
        logic [PERIOD_W-1:0] gap_time;
        logic [PERIOD_W-1:0] repeat_time;
        logic                repeat_enable;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic                carrier_on;
        logic [PERIOD_W-1:0] next_period;
        logic                active;
    } result_t;

    typedef struct packed {
        logic             en;
        logic [DB_AW-1:0] addr;
        logic [7:0]       data;
    } mem_wr_t;

endpackage

@@ src/ipte_if.sv @@
// Valid/ready channel interfaces for items and results.
interface ipte_item_if;
    import ipte_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output kind, output index, output value, input ready);
    modport sink (input valid, input kind, input index, input value, output ready);
endinterface

interface ipte_result_if;
    import ipte_pkg::*;

    logic                valid;
    logic                ready;
    logic                carrier_on;
    logic [PERIOD_W-1:0] next_period;
    logic                active;

    modport source (output valid, output carrier_on, output next_period, output active,
                    input ready);
    modport sink (input valid, input carrier_on, input next_period, input active,
                  output ready);
endinterface

@@ src/ipte_cfg.sv @@
// Configuration register file of the pulse timing encoder.
module ipte_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ipte_pkg::CFG_AW-1:0]  cfg_index,
    input  logic [ipte_pkg::CFG_DW-1:0]  cfg_data,
    output ipte_pkg::cfg_t               cfg,
    output logic [ipte_pkg::MODE_W-1:0]  mode_next
);
    import ipte_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:        cfg_next.encoding_mode     = cfg_data[MODE_W-1:0];
                CFG_BIT_COUNT:   cfg_next.bit_count         = cfg_data[BITPOS_W-1:0];
                CFG_PULSE_COUNT: cfg_next.start_pulse_count = cfg_data[PULSE_W-1:0];
                CFG_HIGH_TIME:   cfg_next.high_time         = cfg_data[PERIOD_W-1:0];
                CFG_LOW_TIME:    cfg_next.low_time          = cfg_data[PERIOD_W-1:0];
                CFG_GAP_TIME:    cfg_next.gap_time          = cfg_data[PERIOD_W-1:0];
                CFG_REPEAT_TIME: cfg_next.repeat_time       = cfg_data[PERIOD_W-1:0];
                CFG_REPEAT_EN:   cfg_next.repeat_enable     = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg       = cfg_reg;
    assign mode_next = cfg_next.encoding_mode;

endmodule

@@ src/ipte_data_mem.sv @@
// Data byte table: one write port, two registered read ports, per-entry valid bits.
module ipte_data_mem (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ipte_pkg::mem_wr_t              wr,
    input  logic [ipte_pkg::BITPOS_W-1:0]  addr_a,
    input  logic [ipte_pkg::BITPOS_W:0]    addr_b,
    output logic [7:0]                     byte_a,
    output logic [7:0]                     byte_b
);
    import ipte_pkg::*;

    logic [7:0]            mem_reg [DATA_BYTES];
    logic [DATA_BYTES-1:0] valid_reg;
    logic [DATA_BYTES-1:0] valid_next;
    logic [7:0]            rd_a_reg;
    logic [7:0]            rd_b_reg;
    logic                  zero_a_reg;
    logic                  zero_b_reg;
    logic                  zero_a_next;
    logic                  zero_b_next;
    logic [DB_AW-1:0]      idx_a;
    logic [DB_AW-1:0]      idx_b;
    logic                  in_a;
    logic                  in_b;
    logic                  hit_a;
    logic                  hit_b;

    assign idx_a = addr_a[DB_AW-1:0];
    assign idx_b = addr_b[DB_AW-1:0];
    assign in_a  = {{(32-BITPOS_W){1'b0}}, addr_a} < DATA_BYTES;
    assign in_b  = {{(31-BITPOS_W){1'b0}}, addr_b} < DATA_BYTES;

    // A write in the same cycle as the read is forwarded to the read data.
    assign hit_a = wr.en && (wr.addr == idx_a) && in_a;
    assign hit_b = wr.en && (wr.addr == idx_b) && in_b;

    assign zero_a_next = !in_a || (!hit_a && !valid_reg[idx_a]);
    assign zero_b_next = !in_b || (!hit_b && !valid_reg[idx_b]);

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        rd_a_reg <= hit_a ? wr.data : mem_reg[idx_a];
        rd_b_reg <= hit_b ? wr.data : mem_reg[idx_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            zero_a_reg <= 1'b1;
            zero_b_reg <= 1'b1;
        end
        else
        begin
            valid_reg  <= valid_next;
            zero_a_reg <= zero_a_next;
            zero_b_reg <= zero_b_next;
        end
    end

    assign byte_a = zero_a_reg ? 8'd0 : rd_a_reg;
    assign byte_b = zero_b_reg ? 8'd0 : rd_b_reg;

endmodule

@@ src/ipte_core.sv @@
// Sequencer state, start pulse table and next-state logic for one item.
module ipte_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  ipte_pkg::item_t                item_q,
    input  ipte_pkg::cfg_t                 cfg,
    input  logic [ipte_pkg::MODE_W-1:0]    mode_next,
    input  logic [7:0]                     byte_a,
    input  logic [7:0]                     byte_b,
    output ipte_pkg::result_t              res,
    output ipte_pkg::mem_wr_t              mem_wr,
    output logic [ipte_pkg::BITPOS_W-1:0]  addr_a,
    output logic [ipte_pkg::BITPOS_W:0]    addr_b
);
    import ipte_pkg::*;

    logic                running_reg, running_next;
    logic                carrier_reg, carrier_next;
    logic                phase_reg, phase_next;
    logic [PULSE_W-1:0]  pulse_pos_reg, pulse_pos_next;
    logic [BITPOS_W-1:0] bit_pos_reg, bit_pos_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [PERIOD_W-1:0] pulses_reg [START_PULSES];

    logic [BITPOS_W:0]   sum1;
    logic [BITPOS_W:0]   sum2;
    logic [BITPOS_W-1:0] adv1;
    logic [BITPOS_W-1:0] adv2;
    logic                cur_bit;
    logic [PERIOD_W-1:0] bit_time;
    logic [PERIOD_W-1:0] inv_time;
    logic [PERIOD_W-1:0] pulse_time;
    logic                pulse_wr;
    logic                toggled;
    logic                frame_done;

    assign sum1 = {1'b0, bit_pos_reg} + {{BITPOS_W{1'b0}}, 1'b1};
    assign sum2 = {1'b0, bit_pos_reg} + {{(BITPOS_W-1){1'b0}}, 2'd2};
    assign adv1 = sum1[BITPOS_W] ? BIT_POS_MAX : sum1[BITPOS_W-1:0];
    assign adv2 = sum2[BITPOS_W] ? BIT_POS_MAX : sum2[BITPOS_W-1:0];

    // Bits go out most significant first within each byte.
    assign cur_bit  = byte_a[~bit_pos_reg[2:0]];
    assign bit_time = cur_bit ? cfg.high_time : cfg.low_time;
    assign inv_time = cur_bit ? cfg.low_time : cfg.high_time;

    assign pulse_time = ({{(32-PULSE_W){1'b0}}, pulse_pos_reg} < START_PULSES)
                        ? pulses_reg[pulse_pos_reg[SP_AW-1:0]] : '0;

    assign toggled    = !phase_reg;
    assign frame_done = (bit_pos_reg >= cfg.bit_count)
                        && (!toggled || (cfg.encoding_mode == MODE_PAIR));

    assign pulse_wr = advance && (item_q.kind == KIND_WPULSE)
                      && ({{(32-INDEX_W){1'b0}}, item_q.index} < START_PULSES);

    assign mem_wr.en   = advance && (item_q.kind == KIND_WDATA)
                         && ({{(32-INDEX_W){1'b0}}, item_q.index} < DATA_BYTES);
    assign mem_wr.addr = item_q.index[DB_AW-1:0];
    assign mem_wr.data = item_q.value[7:0];

    always_comb
    begin
        running_next   = running_reg;
        carrier_next   = carrier_reg;
        phase_next     = phase_reg;
        pulse_pos_next = pulse_pos_reg;
        bit_pos_next   = bit_pos_reg;
        period_next    = period_reg;
        if (advance)
        begin
            unique case (item_q.kind)
                KIND_EVENT:
                begin
                    if (running_reg)
                    begin
                        carrier_next = toggled;
                        phase_next   = toggled;
                        if (frame_done)
                        begin
                            if (cfg.encoding_mode == MODE_PAIR)
                            begin
                                carrier_next = 1'b0;
                            end
                            if (!cfg.repeat_enable)
                            begin
                                running_next = 1'b0;
                                carrier_next = 1'b0;
                            end
                            else
                            begin
                                pulse_pos_next = '0;
                                phase_next     = 1'b0;
                                bit_pos_next   = '0;
                                period_next    = cfg.repeat_time;
                            end
                        end
                        else if (pulse_pos_reg < cfg.start_pulse_count)
                        begin
                            period_next    = pulse_time;
                            pulse_pos_next = pulse_pos_reg + {{(PULSE_W-1){1'b0}}, 1'b1};
                        end
                        else
                        begin
                            unique case (cfg.encoding_mode)
                                MODE_ALT:
                                begin
                                    period_next  = bit_time;
                                    bit_pos_next = adv1;
                                end
                                MODE_PULSE:
                                begin
                                    if (toggled)
                                    begin
                                        period_next  = bit_time;
                                        bit_pos_next = adv1;
                                    end
                                    else
                                    begin
                                        period_next = cfg.gap_time;
                                    end
                                end
                                MODE_SPACE:
                                begin
                                    if (!toggled)
                                    begin
                                        period_next = bit_time;
                                    end
                                    else
                                    begin
                                        period_next  = cfg.gap_time;
                                        bit_pos_next = adv1;
                                    end
                                end
                                MODE_PAIR:
                                begin
                                    if (!toggled)
                                    begin
                                        period_next  = inv_time;
                                        bit_pos_next = adv1;
                                    end
                                    else
                                    begin
                                        period_next = bit_time;
                                    end
                                end
                                MODE_RAW:
                                begin
                                    period_next  = {byte_a, byte_b};
                                    bit_pos_next = adv2;
                                end
                                default:
                                begin
                                    period_next = period_reg;
                                end
                            endcase
                        end
                    end
                end
                KIND_START:
                begin
                    pulse_pos_next = '0;
                    phase_next     = 1'b0;
                    bit_pos_next   = '0;
                    running_next   = 1'b1;
                end
                KIND_STOP:
                begin
                    running_next = 1'b0;
                    carrier_next = 1'b0;
                end
                default:
                begin
                    running_next = running_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            carrier_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            pulse_pos_reg <= '0;
            bit_pos_reg   <= '0;
            period_reg    <= '1;
            for (int i = 0; i < START_PULSES; i++)
            begin
                pulses_reg[i] <= '0;
            end
        end
        else
        begin
            running_reg   <= running_next;
            carrier_reg   <= carrier_next;
            phase_reg     <= phase_next;
            pulse_pos_reg <= pulse_pos_next;
            bit_pos_reg   <= bit_pos_next;
            period_reg    <= period_next;
            if (pulse_wr)
            begin
                pulses_reg[item_q.index[SP_AW-1:0]] <= item_q.value;
            end
        end
    end

    // The data table is read ahead from the position the next item will see.
    assign addr_a = (mode_next == MODE_RAW) ? bit_pos_next
                    : {3'b000, bit_pos_next[BITPOS_W-1:3]};
    assign addr_b = {1'b0, bit_pos_next} + {{BITPOS_W{1'b0}}, 1'b1};

    assign res.carrier_on  = carrier_next;
    assign res.next_period = period_next;
    assign res.active      = running_next;

endmodule

@@ src/ir_pulse_timing_encoder.sv @@
// Top level of the infrared pulse timing encoder.
// The encoder takes one item per clock cycle while the result output is not stalled and
// gives one result per item: an input register holds the item, the sequencer updates its
// state and the result register captures carrier gate, next period and activity. The
// input register lets a new item transfer while a finished result waits downstream.
// The data byte table is a 64 x 8 memory with two registered read ports that is read
// ahead from the bit position the next item will use, so its data is ready for that item;
// per-entry valid bits make it read as zero after reset without any clearing pass.
module ir_pulse_timing_encoder (
    input  logic                         clk,
    input  logic                         rst_n,
    ipte_item_if.sink                    item,
    ipte_result_if.source                result,
    input  logic                         cfg_we,
    input  logic [ipte_pkg::CFG_AW-1:0]  cfg_index,
    input  logic [ipte_pkg::CFG_DW-1:0]  cfg_data
);
    import ipte_pkg::*;

    item_t               item_reg;
    logic                in_valid_reg, in_valid_next;
    result_t             res_reg;
    logic                out_valid_reg, out_valid_next;
    logic                advance;
    cfg_t                cfg;
    logic [MODE_W-1:0]   mode_next;
    result_t             res_next;
    mem_wr_t             mem_wr;
    logic [BITPOS_W-1:0] addr_a;
    logic [BITPOS_W:0]   addr_b;
    logic [7:0]          byte_a;
    logic [7:0]          byte_b;
    logic                take;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign take       = item.valid && item.ready;

    assign in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind  <= item.kind;
            item_reg.index <= item.index;
            item_reg.value <= item.value;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    ipte_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .mode_next (mode_next)
    );

    ipte_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item_q    (item_reg),
        .cfg       (cfg),
        .mode_next (mode_next),
        .byte_a    (byte_a),
        .byte_b    (byte_b),
        .res       (res_next),
        .mem_wr    (mem_wr),
        .addr_a    (addr_a),
        .addr_b    (addr_b)
    );

    ipte_data_mem u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (mem_wr),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .byte_a (byte_a),
        .byte_b (byte_b)
    );

    assign result.valid       = out_valid_reg;
    assign result.carrier_on  = res_reg.carrier_on;
    assign result.next_period = res_reg.next_period;
    assign result.active      = res_reg.active;

endmodule

@@ src/ipte_checker.sv @@
// Port-level assertions for the pulse timing encoder and their binding.
module ipte_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic                          carrier_on,
    input logic [ipte_pkg::PERIOD_W-1:0] next_period,
    input logic                          active
);
    import ipte_pkg::*;

    // A stalled result keeps its contents until the transfer.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(carrier_on)
            && $stable(next_period) && $stable(active))
        else $error("result changed while stalled");

    // The carrier gate is only ever on while the sequence runs.
    a_carrier_active: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && carrier_on |-> active)
        else $error("carrier on while inactive");

    // Items are refused only when a result is waiting for a stalled sink.
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("item refused without output back-pressure");

endmodule

bind ir_pulse_timing_encoder ipte_checker u_ipte_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .carrier_on   (result.carrier_on),
    .next_period  (result.next_period),
    .active       (result.active)
);
